// ----- design/ppu_pkg.sv -----
package ppu_pkg;

	typedef enum logic [1:0] {
		OP_PALETTE = 2'd0,
		OP_DATA    = 2'd1,
		OP_SOF     = 2'd2,
		OP_UNUSED  = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		REG_BPP    = 2'd0,
		REG_WIDTH  = 2'd1,
		REG_HEIGHT = 2'd2,
		REG_NONE   = 2'd3
	} reg_index_t;

	localparam logic KIND_CLEAR = 1'b0;
	localparam logic KIND_DRAW  = 1'b1;

	typedef struct packed {
		logic [3:0] bpp;
		logic [6:0] width;
		logic [6:0] height;
	} cfg_t;

	// one decoded index (or a clear) on its way to the result stage
	typedef struct packed {
		logic       valid;
		logic       clear;
		logic       fin;
		logic       oob;
		logic [5:0] column;
		logic [5:0] row;
	} evt_t;

	typedef struct packed {
		logic        kind;
		logic [5:0]  column;
		logic [5:0]  row;
		logic [15:0] color;
	} res_t;

	function automatic logic [15:0] to_rgb565(input logic [23:0] rgb);
		return {rgb[23:19], rgb[15:10], rgb[7:3]};
	endfunction

endpackage

// ----- design/ppu_ram.sv -----
module ppu_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// read-first on a same-address collision
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- design/ppu_unpack.sv -----
module ppu_unpack #(
	parameter int PALETTE_DEPTH = 256,
	parameter int MAX_DIMENSION = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  ppu_pkg::cfg_t                    cfg,
	input  logic                             cfg_bpp_wr,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [1:0]                       opcode,
	input  logic [7:0]                       data_byte,
	input  logic [7:0]                       palette_index,
	input  logic [7:0]                       red,
	input  logic [7:0]                       green,
	input  logic [7:0]                       blue,
	output logic                             ram_we,
	output logic [$clog2(PALETTE_DEPTH)-1:0] ram_waddr,
	output logic [23:0]                      ram_wdata,
	output logic                             ram_re,
	output logic [$clog2(PALETTE_DEPTH)-1:0] ram_raddr,
	input  logic                             advance,
	output ppu_pkg::evt_t                    evt_s1
);

	localparam int AW = $clog2(PALETTE_DEPTH);
	localparam int DW = $clog2(MAX_DIMENSION + 1);
	localparam logic [7:0] MaxDim8 = 8'(MAX_DIMENSION);
	localparam logic [8:0] Depth9  = 9'(PALETTE_DEPTH);

	logic [14:0]   acc_q;
	logic [3:0]    avail_q;
	logic          busy_q;
	logic [DW-1:0] col_q;
	logic [DW-1:0] row_q;

	logic [3:0]    eff;
	logic [7:0]    mask8;
	logic [7:0]    idx;
	logic [14:0]   acc_sh;
	logic [3:0]    avail_sh;
	logic [7:0]    w8;
	logic [7:0]    h8;
	logic [DW-1:0] width;
	logic [DW-1:0] height;
	logic [DW-1:0] col_step;
	logic [DW-1:0] row_step;
	logic          row_done;
	logic          step_end;
	logic          step;
	logic          accept;
	logic [14:0]   acc_b;
	logic [3:0]    avail_b;
	logic [DW-1:0] col_b;
	logic [DW-1:0] row_b;
	logic          busy_b;
	logic [31:0]   col32;
	logic [31:0]   row32;

	always_comb begin
		if (cfg.bpp == 4'd0) begin
			eff = 4'd1;
		end else if (cfg.bpp > 4'd8) begin
			eff = 4'd8;
		end else begin
			eff = cfg.bpp;
		end
		w8 = {1'b0, cfg.width};
		h8 = {1'b0, cfg.height};
		if (w8 == 8'd0) begin
			w8 = 8'd1;
		end else if (w8 > MaxDim8) begin
			w8 = MaxDim8;
		end
		if (h8 == 8'd0) begin
			h8 = 8'd1;
		end else if (h8 > MaxDim8) begin
			h8 = MaxDim8;
		end
		width  = w8[DW-1:0];
		height = h8[DW-1:0];
	end

	assign mask8    = 8'hFF >> (4'd8 - eff);
	assign idx      = acc_q[7:0] & mask8;
	assign acc_sh   = acc_q >> eff;
	assign avail_sh = avail_q - eff;

	always_comb begin
		if (({1'b0, col_q} + 1'b1) >= {1'b0, width}) begin
			col_step = '0;
			row_step = row_q + 1'b1;
		end else begin
			col_step = col_q + 1'b1;
			row_step = row_q;
		end
	end

	assign row_done = row_step >= height;
	assign step_end = (avail_sh < eff) || row_done;
	assign step     = busy_q && advance;

	always_comb begin
		if (step) begin
			col_b  = col_step;
			row_b  = row_step;
			busy_b = !step_end;
			if (row_done) begin
				acc_b   = '0;
				avail_b = '0;
			end else if (step_end) begin
				acc_b   = {8'd0, acc_sh[6:0]};
				avail_b = avail_sh;
			end else begin
				acc_b   = acc_sh;
				avail_b = avail_sh;
			end
		end else begin
			col_b   = col_q;
			row_b   = row_q;
			busy_b  = busy_q;
			acc_b   = acc_q;
			avail_b = avail_q;
		end
	end

	// a start of frame needs the event slot, so it never overlaps a step
	assign in_ready = advance &&
		(!busy_q || (step_end && opcode != ppu_pkg::OP_SOF));
	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			avail_q <= '0;
			busy_q  <= 1'b0;
			col_q   <= '0;
			row_q   <= '0;
		end else begin
			acc_q   <= acc_b;
			avail_q <= avail_b;
			busy_q  <= busy_b;
			col_q   <= col_b;
			row_q   <= row_b;
			if (accept) begin
				unique case (opcode)
					ppu_pkg::OP_DATA: begin
						if (row_b < height) begin
							acc_q   <= acc_b | (15'({7'd0, data_byte}) << avail_b);
							avail_q <= avail_b + 4'd8;
							busy_q  <= 1'b1;
						end
					end
					ppu_pkg::OP_SOF: begin
						acc_q   <= '0;
						avail_q <= '0;
						col_q   <= '0;
						row_q   <= '0;
					end
					default: begin
					end
				endcase
			end
			if (cfg_bpp_wr) begin
				acc_q   <= '0;
				avail_q <= '0;
			end
		end
	end

	assign col32 = 32'(col_q);
	assign row32 = 32'(row_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_s1 <= '0;
		end else if (advance) begin
			evt_s1.valid  <= step || (accept && opcode == ppu_pkg::OP_SOF);
			evt_s1.clear  <= !step;
			evt_s1.fin    <= step ? step_end : 1'b1;
			evt_s1.oob    <= {1'b0, idx} >= Depth9;
			evt_s1.column <= step ? col32[5:0] : 6'd0;
			evt_s1.row    <= step ? row32[5:0] : 6'd0;
		end
	end

	assign ram_re    = step;
	assign ram_raddr = idx[AW-1:0];
	assign ram_we    = accept && opcode == ppu_pkg::OP_PALETTE &&
		{1'b0, palette_index} < Depth9;
	assign ram_waddr = palette_index[AW-1:0];
	assign ram_wdata = {red, green, blue};

endmodule

// ----- design/ppu_out.sv -----
module ppu_out (
	input  logic          clk,
	input  logic          arst_n,
	input  ppu_pkg::evt_t evt_s1,
	input  logic [23:0]   rdata,
	output logic          advance,
	output logic          out_valid,
	input  logic          out_ready,
	output logic          kind,
	output logic [5:0]    column,
	output logic [5:0]    row,
	output logic [15:0]   color,
	output logic          last
);

	ppu_pkg::res_t pend_q;
	ppu_pkg::res_t res_q;
	ppu_pkg::res_t evt_res;
	logic          pend_valid_q;
	logic          pend_fin_q;
	logic          out_valid_q;
	logic          last_q;
	logic          draw_hit;
	logic          skip_fin;
	logic          can_out;
	logic          release_pend;

	// black and out-of-range entries are skipped
	assign draw_hit = evt_s1.valid &&
		(evt_s1.clear || (!evt_s1.oob && rdata != 24'd0));
	assign skip_fin = evt_s1.valid && !draw_hit && evt_s1.fin;
	assign can_out  = !out_valid_q || out_ready;

	// hold one result back so last can be set once the word's end is known
	assign release_pend = pend_valid_q && (pend_fin_q || draw_hit) && can_out;
	assign advance      = !draw_hit || !pend_valid_q || release_pend;

	always_comb begin
		if (evt_s1.clear) begin
			evt_res = '{kind: ppu_pkg::KIND_CLEAR, column: 6'd0, row: 6'd0, color: 16'd0};
		end else begin
			evt_res = '{kind: ppu_pkg::KIND_DRAW, column: evt_s1.column, row: evt_s1.row,
				color: ppu_pkg::to_rgb565(rdata)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			pend_fin_q   <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (draw_hit && advance) begin
				pend_valid_q <= 1'b1;
				pend_fin_q   <= evt_s1.fin;
			end else if (release_pend) begin
				pend_valid_q <= 1'b0;
			end else if (skip_fin && pend_valid_q) begin
				pend_fin_q <= 1'b1;
			end
			if (release_pend) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (draw_hit && advance) begin
			pend_q <= evt_res;
		end
		if (release_pend) begin
			res_q  <= pend_q;
			last_q <= pend_fin_q;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = res_q.kind;
	assign column    = res_q.column;
	assign row       = res_q.row;
	assign color     = res_q.color;
	assign last      = last_q;

endmodule

// ----- design/palette_pixel_unpacker.sv -----
// Palette write and unused opcodes: taken when idle or with a word's final index.
// Data word: one decoded index per cycle while the result stage advances; the next
// word is taken during the final index. Start of frame: taken once the sequencer
// is idle. A result goes through evt_s1 and the palette read, then the pending and
// output registers, held in pending until the word's next drawn or final index.
// Reset clears control and registers (1 bpp, 64x32); palette stays undefined.
module palette_pixel_unpacker #(
	parameter int PALETTE_DEPTH = 256,
	parameter int MAX_DIMENSION = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [1:0]  cfg_index,
	input  logic [6:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic [7:0]  data_byte,
	input  logic [7:0]  palette_index,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic [5:0]  column,
	output logic [5:0]  row,
	output logic [15:0] color,
	output logic        last
);

	localparam int AW = $clog2(PALETTE_DEPTH);

	ppu_pkg::cfg_t cfg_q;
	ppu_pkg::evt_t evt_s1;
	logic          cfg_bpp_wr;
	logic          advance;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [23:0]   ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [23:0]   ram_rdata;

	assign cfg_bpp_wr = cfg_wen && cfg_index == ppu_pkg::REG_BPP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bpp    <= 4'd1;
			cfg_q.width  <= 7'd64;
			cfg_q.height <= 7'd32;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				ppu_pkg::REG_BPP:    cfg_q.bpp    <= cfg_data[3:0];
				ppu_pkg::REG_WIDTH:  cfg_q.width  <= cfg_data;
				ppu_pkg::REG_HEIGHT: cfg_q.height <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	ppu_unpack #(
		.PALETTE_DEPTH(PALETTE_DEPTH),
		.MAX_DIMENSION(MAX_DIMENSION)
	) u_unpack (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.cfg_bpp_wr   (cfg_bpp_wr),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.data_byte    (data_byte),
		.palette_index(palette_index),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.ram_we       (ram_we),
		.ram_waddr    (ram_waddr),
		.ram_wdata    (ram_wdata),
		.ram_re       (ram_re),
		.ram_raddr    (ram_raddr),
		.advance      (advance),
		.evt_s1       (evt_s1)
	);

	ppu_ram #(
		.WIDTH(24),
		.DEPTH(PALETTE_DEPTH)
	) u_palette (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	ppu_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.evt_s1   (evt_s1),
		.rdata    (ram_rdata),
		.advance  (advance),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind     (kind),
		.column   (column),
		.row      (row),
		.color    (color),
		.last     (last)
	);

endmodule

// ----- design/ppu_checker.sv -----
module ppu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_wen,
	input logic [1:0]  cfg_index,
	input logic [6:0]  cfg_data,
	input logic        in_valid,
	input logic        in_ready,
	input logic [1:0]  opcode,
	input logic [7:0]  data_byte,
	input logic [7:0]  palette_index,
	input logic [7:0]  red,
	input logic [7:0]  green,
	input logic [7:0]  blue,
	input logic        out_valid,
	input logic        out_ready,
	input logic        kind,
	input logic [5:0]  column,
	input logic [5:0]  row,
	input logic [15:0] color,
	input logic        last
);

	a_reset_idle: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result valid during reset");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
			out_valid && $stable(kind) && $stable(column) && $stable(row) &&
			$stable(color) && $stable(last))
		else $error("stalled result changed");

	a_clear_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == ppu_pkg::KIND_CLEAR |-> last)
		else $error("clear result without last");

	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == ppu_pkg::KIND_CLEAR |->
			column == 6'd0 && row == 6'd0 && color == 16'd0)
		else $error("clear result with nonzero fields");

endmodule

bind palette_pixel_unpacker ppu_checker u_ppu_checker (.*);
